// File: rtl/stdist_pkg.sv
// stdist_pkg: shared constants, types and the tanh lookup table of the stereo distortion unit
// used by stdist_lane, stdist_ctrl and stereo_tanh_distortion_unit; depends on nothing

package stdist_pkg;

    // sample format and table geometry
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int TANH_DEPTH  = 1024;
    localparam int TAB_BITS    = $clog2(TANH_DEPTH);
    localparam int ADDR_BITS   = TAB_BITS + 1;
    localparam int TAB_W       = SAMPLE_BITS;
    localparam int LP_GUARD    = (SAMPLE_BITS < 31) ? (31 - SAMPLE_BITS) : 0;
    localparam int LP_BITS     = 32;

    // stream and configuration port widths
    localparam int TDATA_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRE_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NORM_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TONE_COEFF  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WET_MIX     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_GAIN = 3'd5;

    // register reset values
    localparam logic        RST_ENABLE      = 1'b1;
    localparam logic [15:0] RST_PRE_GAIN    = 16'd3724;
    localparam logic [14:0] RST_NORM_GAIN   = 15'd16407;
    localparam logic [15:0] RST_TONE_COEFF  = 16'd34642;
    localparam logic [16:0] RST_WET_MIX     = 17'd65536;
    localparam logic [14:0] RST_OUTPUT_GAIN = 15'd16384;

    // unity in the Q1.16 mix format
    localparam logic [16:0] WET_FULL = 17'h10000;

    localparam logic [63:0] ONE_Q31 = 64'h0000_0000_8000_0000;

    // settings seen by both lanes (wet share already limited to unity)
    typedef struct packed {
        logic        enable;
        logic [15:0] pre_gain;
        logic [14:0] norm_gain;
        logic [15:0] tone_coeff;
        logic [16:0] wet_mix;
        logic [14:0] output_gain;
    } t_cfg;

    // step strobes from the sequencer to the lanes
    typedef struct packed {
        logic load;
        logic pre;
        logic rom;
        logic interp;
        logic norm;
        logic tone;
        logic lp;
        logic mix;
        logic sum;
        logic gain;
    } t_lane_ctl;

    typedef logic [TANH_DEPTH:0][TAB_W-1:0] t_tanh_rom;

    // shift-and-subtract quotient, only used while the table is built
    function automatic logic [63:0] quot_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        int          i;
        q   = '0;
        rem = '0;
        for (i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // tanh(8k/depth) in Q1.F via exp(-16k/depth): series in Q0.31, then four squarings
    function automatic logic [TAB_W-1:0] tanh_entry(input int k);
        logic [63:0]        f;
        logic [63:0]        term;
        logic [63:0]        v;
        logic [63:0]        den;
        logic [63:0]        num;
        logic [63:0]        q;
        logic signed [63:0] sum;
        int                 n;
        f    = quot_u64(64'(k) << 31, 64'(TANH_DEPTH));
        term = ONE_Q31;
        sum  = $signed(ONE_Q31);
        for (n = 1; n <= 13; n++) begin
            term = quot_u64((term * f) >> 31, 64'(n));
            if (n[0]) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        v = (sum < 0) ? 64'd0 : 64'(sum);
        for (n = 0; n < 4; n++) begin
            v = (v * v + (ONE_Q31 >> 1)) >> 31;
        end
        den = ONE_Q31 + v;
        num = (ONE_Q31 - v) << FRAC_BITS;
        q   = quot_u64(num + (den >> 1), den);
        return q[TAB_W-1:0];
    endfunction

    function automatic t_tanh_rom build_tanh_rom();
        t_tanh_rom rom;
        int        k;
        for (k = 0; k <= TANH_DEPTH; k++) begin
            rom[k] = tanh_entry(k);
        end
        return rom;
    endfunction

    // tanh table, one entry beyond the last step for interpolation
    localparam t_tanh_rom TANH_ROM = build_tanh_rom();

endpackage

// File: rtl/stdist_lane.sv
// stdist_lane: one channel of the distortion datapath, one arithmetic step per strobe
// depends on stdist_pkg (widths, t_cfg, t_lane_ctl, TANH_ROM)

module stdist_lane (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  stdist_pkg::t_lane_ctl                   i_ctl,
    input  stdist_pkg::t_cfg                        i_cfg,
    input  logic signed [stdist_pkg::SAMPLE_BITS-1:0] i_x,
    output logic signed [stdist_pkg::SAMPLE_BITS-1:0] o_y
);

    localparam int SB       = stdist_pkg::SAMPLE_BITS;
    localparam int FB       = stdist_pkg::FRAC_BITS;
    localparam int TB       = stdist_pkg::TAB_BITS;
    localparam int AB       = stdist_pkg::ADDR_BITS;
    localparam int TW       = stdist_pkg::TAB_W;
    localparam int G        = stdist_pkg::LP_GUARD;
    localparam int LB       = stdist_pkg::LP_BITS;
    localparam int P_BITS   = SB + 17;
    localparam int MAG_BITS = SB + 15;
    localparam int NP_BITS  = TW + 17;
    localparam int W_BITS   = SB + 2;
    localparam int WG_BITS  = W_BITS + G;
    localparam int D_BITS   = WG_BITS + 1;
    localparam int TP_BITS  = D_BITS + 17;
    localparam int LPN_BITS = TP_BITS - 15;
    localparam int SUM_BITS = LB + 19;
    localparam int M_BITS   = SUM_BITS - 16;
    localparam int YP_BITS  = M_BITS + 16;

    localparam logic [AB-1:0]             ROM_LAST = AB'(stdist_pkg::TANH_DEPTH);
    localparam logic signed [NP_BITS-1:0]  NP_HALF  = NP_BITS'(1) << 13;
    localparam logic signed [TP_BITS-1:0]  TP_HALF  = TP_BITS'(1) << 15;
    localparam logic signed [SUM_BITS-1:0] SUM_HALF = SUM_BITS'(1) << 15;
    localparam logic signed [YP_BITS-1:0]  YP_HALF  = YP_BITS'(1) << (13 + G);
    localparam logic signed [LPN_BITS-1:0] LPN_MAX  = (LPN_BITS'(1) << (LB - 1)) - LPN_BITS'(1);
    localparam logic signed [LPN_BITS-1:0] LPN_MIN  = -(LPN_BITS'(1) << (LB - 1));
    localparam logic signed [YP_BITS-1:0]  Y_MAX    = (YP_BITS'(1) << FB) - YP_BITS'(1);
    localparam logic signed [YP_BITS-1:0]  Y_MIN    = -(YP_BITS'(1) << FB);

    logic signed [SB-1:0]       r_x;
    logic signed [P_BITS-1:0]   r_p;
    logic [TW-1:0]              r_a;
    logic [TW-1:0]              r_b;
    logic [15:0]                r_frac;
    logic                       r_neg;
    logic [TW-1:0]              r_t;
    logic signed [W_BITS-1:0]   r_w;
    logic signed [TP_BITS-1:0]  r_tprod;
    logic signed [LB-1:0]       r_lp;
    logic signed [LB-1:0]       r_lpn;
    logic signed [SUM_BITS-1:0] r_dry;
    logic signed [SUM_BITS-1:0] r_wet;
    logic signed [M_BITS-1:0]   r_m;
    logic signed [YP_BITS-1:0]  r_yp;

    logic [P_BITS-1:0]          p_abs;
    logic [MAG_BITS-1:0]        mag;
    logic                       beyond;
    logic [TB-1:0]              idx_lo;
    logic [15:0]                frac;
    logic [AB-1:0]              addr_a;
    logic [AB-1:0]              addr_b;
    logic                       rising;
    logic [TW-1:0]              diff;
    logic [TW+15:0]             iprod;
    logic [TW-1:0]              step;
    logic [TW-1:0]              t_val;
    logic signed [TW:0]         t_signed;
    logic signed [NP_BITS-1:0]  np;
    logic signed [WG_BITS-1:0]  wg;
    logic signed [D_BITS-1:0]   d;
    logic signed [TP_BITS-1:0]  tr;
    logic signed [LPN_BITS-1:0] lpn_wide;
    logic signed [LB-1:0]       lpn_sat;
    logic [16:0]                dry_share;
    logic signed [SUM_BITS-1:0] xg;
    logic signed [SUM_BITS-1:0] msum;
    logic signed [YP_BITS-1:0]  yr;
    logic signed [YP_BITS-1:0]  ys;
    logic signed [SB-1:0]       y_sat;

    // table address, interpolation fraction and drive beyond the table
    always_comb begin
        p_abs  = r_p[P_BITS-1] ? P_BITS'(-r_p) : P_BITS'(r_p);
        mag    = p_abs[MAG_BITS-1:0];
        beyond = |mag[MAG_BITS-1:FB+13];
        idx_lo = mag[FB+12 -: TB];
        frac   = mag[FB-3-TB +: 16];
        addr_a = beyond ? ROM_LAST : {1'b0, idx_lo};
        addr_b = beyond ? ROM_LAST : ({1'b0, idx_lo} + AB'(1));
    end

    // truncating linear interpolation between neighbouring entries
    always_comb begin
        rising = (r_b >= r_a);
        diff   = rising ? (r_b - r_a) : (r_a - r_b);
        iprod  = (TW + 16)'(diff) * (TW + 16)'(r_frac);
        step   = iprod[TW+15:16];
        t_val  = rising ? (r_a + step) : (r_a - step);
    end

    // sign restore and normalising gain
    always_comb begin
        t_signed = r_neg ? -$signed({1'b0, r_t}) : $signed({1'b0, r_t});
        np       = NP_BITS'(t_signed) * NP_BITS'($signed({1'b0, i_cfg.norm_gain}))
                   + NP_HALF;
    end

    // one-pole low-pass with saturation of the state
    always_comb begin
        wg       = WG_BITS'(r_w) <<< G;
        d        = D_BITS'(r_lp) - D_BITS'(wg);
        tr       = r_tprod + TP_HALF;
        lpn_wide = LPN_BITS'(wg) + LPN_BITS'($signed(tr[TP_BITS-1:16]));
        if (lpn_wide > LPN_MAX) begin
            lpn_sat = LB'(LPN_MAX);
        end else if (lpn_wide < LPN_MIN) begin
            lpn_sat = LB'(LPN_MIN);
        end else begin
            lpn_sat = LB'(lpn_wide);
        end
    end

    // dry/wet mix, output rounding and saturation
    always_comb begin
        dry_share = stdist_pkg::WET_FULL - i_cfg.wet_mix;
        xg        = SUM_BITS'(r_x) <<< G;
        msum      = r_dry + r_wet + SUM_HALF;
        yr        = r_yp + YP_HALF;
        ys        = yr >>> (14 + G);
        if (ys > Y_MAX) begin
            y_sat = SB'(Y_MAX);
        end else if (ys < Y_MIN) begin
            y_sat = SB'(Y_MIN);
        end else begin
            y_sat = SB'(ys);
        end
        o_y = i_cfg.enable ? y_sat : r_x;
    end

    // datapath registers, each written by its own step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
        end
        if (i_ctl.pre) begin
            r_p <= P_BITS'(r_x) * P_BITS'($signed({1'b0, i_cfg.pre_gain}));
        end
        if (i_ctl.rom) begin
            r_a    <= stdist_pkg::TANH_ROM[addr_a];
            r_b    <= stdist_pkg::TANH_ROM[addr_b];
            r_frac <= frac;
            r_neg  <= r_p[P_BITS-1];
        end
        if (i_ctl.interp) begin
            r_t <= t_val;
        end
        if (i_ctl.norm) begin
            r_w <= $signed(np[14 +: W_BITS]);
        end
        if (i_ctl.tone) begin
            r_tprod <= TP_BITS'(d) * TP_BITS'($signed({1'b0, i_cfg.tone_coeff}));
        end
        if (i_ctl.lp) begin
            r_lpn <= lpn_sat;
        end
        if (i_ctl.mix) begin
            r_dry <= xg * SUM_BITS'($signed({1'b0, dry_share}));
            r_wet <= SUM_BITS'(r_lpn) * SUM_BITS'($signed({1'b0, i_cfg.wet_mix}));
        end
        if (i_ctl.sum) begin
            r_m <= $signed(msum[16 +: M_BITS]);
        end
        if (i_ctl.gain) begin
            r_yp <= YP_BITS'(r_m) * YP_BITS'($signed({1'b0, i_cfg.output_gain}));
        end
    end

    // filter state, held while the effect is off
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp <= '0;
        end else if (i_ctl.lp && i_cfg.enable) begin
            r_lp <= lpn_sat;
        end
    end

endmodule

// File: rtl/stdist_ctrl.sv
// stdist_ctrl: step sequencer and output handshake of the stereo distortion unit
// depends on stdist_pkg (t_lane_ctl)

module stdist_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_out_load,
    output stdist_pkg::t_lane_ctl o_lane_ctl
);

    typedef enum logic [10:0] {
        ST_IDLE   = 11'b00000000001,
        ST_PRE    = 11'b00000000010,
        ST_ROM    = 11'b00000000100,
        ST_INTERP = 11'b00000001000,
        ST_NORM   = 11'b00000010000,
        ST_TONE   = 11'b00000100000,
        ST_LP     = 11'b00001000000,
        ST_MIX    = 11'b00010000000,
        ST_SUM    = 11'b00100000000,
        ST_GAIN   = 11'b01000000000,
        ST_SAT    = 11'b10000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_load;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_load = (r_state == ST_SAT) && (!r_out_valid || i_out_ready);

    // one step per cycle, final step waits for the output register
    always_comb begin
        unique case (r_state)
            ST_IDLE:   n_state = i_in_valid ? ST_PRE : ST_IDLE;
            ST_PRE:    n_state = ST_ROM;
            ST_ROM:    n_state = ST_INTERP;
            ST_INTERP: n_state = ST_NORM;
            ST_NORM:   n_state = ST_TONE;
            ST_TONE:   n_state = ST_LP;
            ST_LP:     n_state = ST_MIX;
            ST_MIX:    n_state = ST_SUM;
            ST_SUM:    n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_SAT;
            ST_SAT:    n_state = out_load ? ST_IDLE : ST_SAT;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // step strobes for both lanes
    always_comb begin
        o_lane_ctl.load   = accept;
        o_lane_ctl.pre    = (r_state == ST_PRE);
        o_lane_ctl.rom    = (r_state == ST_ROM);
        o_lane_ctl.interp = (r_state == ST_INTERP);
        o_lane_ctl.norm   = (r_state == ST_NORM);
        o_lane_ctl.tone   = (r_state == ST_TONE);
        o_lane_ctl.lp     = (r_state == ST_LP);
        o_lane_ctl.mix    = (r_state == ST_MIX);
        o_lane_ctl.sum    = (r_state == ST_SUM);
        o_lane_ctl.gain   = (r_state == ST_GAIN);
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_load  = out_load;

endmodule

// File: rtl/stereo_tanh_distortion_unit.sv
// stereo_tanh_distortion_unit: top level, register file, two channel lanes and output merge
// depends on stdist_pkg, stdist_ctrl and stdist_lane
//
// usage
//   input stream: one stereo frame per request, left sample in tdata[23:0], right in [47:24]
//   output stream: the processed frame in the same packing, saturated to 24 bits
//   register port: i_cfg_wr_en with i_cfg_index and i_cfg_data writes one register per edge;
//     user must write only while no frame is in flight, unenforced; unknown indexes ignored
//   both channels run in lanes side by side; each lane walks ten arithmetic steps
//     (pre-gain, table read, interpolation, normalising gain, filter multiply, filter update,
//     mix, sum, output gain, saturation), one per cycle, the last held on an output stall
//   result: valid once the saturation step loads the output register
//   one frame in flight at a time, set by the step sequence and the filter feedback
//   the next frame is taken while a finished result waits in the output register; a stalled
//     receiver holds the last step until the output register frees, then input stalls too
//   with the effect off, samples pass unchanged at the same latency and filter state holds
//   reset: registers return to their defaults, filter state clears, output valid drops

module stereo_tanh_distortion_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // stream in
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [stdist_pkg::TDATA_BITS-1:0]      i_s_axis_tdata,  // left_in, right_in
    // stream out
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [stdist_pkg::TDATA_BITS-1:0]      o_m_axis_tdata,  // left_out, right_out
    // register writes
    input  logic                                   i_cfg_wr_en,
    input  logic [stdist_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [stdist_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int SB = stdist_pkg::SAMPLE_BITS;

    logic        r_enable;
    logic [15:0] r_pre_gain;
    logic [14:0] r_norm_gain;
    logic [15:0] r_tone_coeff;
    logic [16:0] r_wet_mix;
    logic [14:0] r_output_gain;

    logic signed [SB-1:0] r_out_left;
    logic signed [SB-1:0] r_out_right;

    stdist_pkg::t_cfg      cfg;
    stdist_pkg::t_lane_ctl lane_ctl;
    logic                  out_load;
    logic signed [SB-1:0]  y_left;
    logic signed [SB-1:0]  y_right;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable      <= stdist_pkg::RST_ENABLE;
            r_pre_gain    <= stdist_pkg::RST_PRE_GAIN;
            r_norm_gain   <= stdist_pkg::RST_NORM_GAIN;
            r_tone_coeff  <= stdist_pkg::RST_TONE_COEFF;
            r_wet_mix     <= stdist_pkg::RST_WET_MIX;
            r_output_gain <= stdist_pkg::RST_OUTPUT_GAIN;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                stdist_pkg::CFG_ENABLE:      r_enable      <= i_cfg_data[0];
                stdist_pkg::CFG_PRE_GAIN:    r_pre_gain    <= i_cfg_data[15:0];
                stdist_pkg::CFG_NORM_GAIN:   r_norm_gain   <= i_cfg_data[14:0];
                stdist_pkg::CFG_TONE_COEFF:  r_tone_coeff  <= i_cfg_data[15:0];
                stdist_pkg::CFG_WET_MIX:     r_wet_mix     <= i_cfg_data[16:0];
                stdist_pkg::CFG_OUTPUT_GAIN: r_output_gain <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // settings for the lanes, wet share limited to unity
    always_comb begin
        cfg.enable      = r_enable;
        cfg.pre_gain    = r_pre_gain;
        cfg.norm_gain   = r_norm_gain;
        cfg.tone_coeff  = r_tone_coeff;
        cfg.wet_mix     = (r_wet_mix > stdist_pkg::WET_FULL) ? stdist_pkg::WET_FULL
                                                              : r_wet_mix;
        cfg.output_gain = r_output_gain;
    end

    stdist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_load  (out_load),
        .o_lane_ctl  (lane_ctl)
    );

    stdist_lane u_lane_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_cfg   (cfg),
        .i_x     ($signed(i_s_axis_tdata[SB-1:0])),
        .o_y     (y_left)
    );

    stdist_lane u_lane_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_cfg   (cfg),
        .i_x     ($signed(i_s_axis_tdata[2*SB-1:SB])),
        .o_y     (y_right)
    );

    // merge both lanes into the output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left  <= y_left;
            r_out_right <= y_right;
        end
    end

    assign o_m_axis_tdata = stdist_pkg::TDATA_BITS'({r_out_right, r_out_left});

endmodule

// File: rtl/stdist_checker.sv
// stdist_checker: port-level assertions for stereo_tanh_distortion_unit, bound to the top level
// depends on stdist_pkg (port widths)

module stdist_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_axis_tvalid,
    input logic                                  o_s_axis_tready,
    input logic [stdist_pkg::TDATA_BITS-1:0]     i_s_axis_tdata,
    input logic                                  o_m_axis_tvalid,
    input logic                                  i_m_axis_tready,
    input logic [stdist_pkg::TDATA_BITS-1:0]     o_m_axis_tdata,
    input logic                                  i_cfg_wr_en,
    input logic [stdist_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input logic [stdist_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    logic in_req;

    assign in_req = i_s_axis_tvalid && o_s_axis_tready;

    // reset empties the output register
    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // one frame in flight: input closes right after a request
    a_single_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> !o_s_axis_tready)
        else $error("input ready straight after a request");

    // a result never appears in the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req |=> !$rose(o_m_axis_tvalid))
        else $error("result appeared one cycle after a request");

    // stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind stereo_tanh_distortion_unit stdist_checker u_checker (.*);

// File: verif/tb_top.sv
// tb_top: self-checking testbench for stereo_tanh_distortion_unit
// drives stereo frames with random idling, predicts every result in a local model and checks it
// depends on stdist_pkg and the rtl of stereo_tanh_distortion_unit

module tb_top;

    // local view of the sample format
    localparam int SB          = stdist_pkg::SAMPLE_BITS;
    localparam int FB          = SB - 1;
    localparam int GUARD       = (SB < 31) ? (31 - SB) : 0;
    localparam int LUT_DEPTH   = stdist_pkg::TANH_DEPTH;
    localparam int IDX_SHIFT   = FB + 13;
    localparam int FRAC_SHIFT  = FB - 3;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 30;

    localparam longint unsigned Q31_UNITY = 64'h0000_0000_8000_0000;
    localparam longint          SAMPLE_MAX = (longint'(1) <<< FB) - 1;
    localparam longint          SAMPLE_MIN = -(longint'(1) <<< FB);
    localparam longint          ACC_MAX    = 64'sd2147483647;
    localparam longint          ACC_MIN    = -64'sd2147483648;

    // register indexes with no register behind them
    localparam logic [stdist_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [stdist_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic [SB-1:0] left;
        logic [SB-1:0] right;
    } t_frame;

    logic                                  i_clk;
    logic                                  i_rst_n;
    logic                                  i_s_axis_tvalid;
    logic                                  o_s_axis_tready;
    logic [stdist_pkg::TDATA_BITS-1:0]     i_s_axis_tdata;
    logic                                  o_m_axis_tvalid;
    logic                                  i_m_axis_tready;
    logic [stdist_pkg::TDATA_BITS-1:0]     o_m_axis_tdata;
    logic                                  i_cfg_wr_en;
    logic [stdist_pkg::CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [stdist_pkg::CFG_DATA_BITS-1:0]  i_cfg_data;

    stereo_tanh_distortion_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // shadow registers and filter state of the predictor
    logic        shadow_enable;
    logic [15:0] shadow_pre_gain;
    logic [14:0] shadow_norm_gain;
    logic [15:0] shadow_tone;
    logic [16:0] shadow_wet;
    logic [14:0] shadow_out_gain;
    longint      lowpass_acc [2];
    longint      tanh_lut [0:LUT_DEPTH];

    t_frame expected_frames [$];

    int errors         = 0;
    int frames_sent    = 0;
    int frames_checked = 0;
    int settings_count = 0;
    int hold_req       = 0;
    bit tx_idle        = 1'b1;
    bit rx_idle        = 1'b1;
    int stall_cycles   = 0;

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // exp(-16k/depth) in Q0.31: series of exp(-k/depth) up to the 13th power, then four squarings
    function automatic longint unsigned exp_neg_q31(input int k);
        longint unsigned f;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        int              n;
        f    = (64'(k) << 31) / 64'(LUT_DEPTH);
        term = Q31_UNITY;
        acc  = longint'(Q31_UNITY);
        for (n = 1; n <= 13; n++) begin
            term = (term * f) / (64'(n) << 31);
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        v = (acc < 0) ? 64'd0 : longint'(acc);
        for (n = 0; n < 4; n++) begin
            v = (v * v + (Q31_UNITY >> 1)) >> 31;
        end
        return v;
    endfunction

    // tanh(8k/depth) in Q1.F, rounded division
    function automatic void fill_tanh_lut();
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        int              k;
        for (k = 0; k <= LUT_DEPTH; k++) begin
            e            = exp_neg_q31(k);
            den          = Q31_UNITY + e;
            num          = (Q31_UNITY - e) << FB;
            tanh_lut[k]  = longint'((num + den / 2) / den);
        end
    endfunction

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // one channel: drive, tanh lookup, normalise, tone filter, mix, output gain
    function automatic logic [SB-1:0] shape_sample(input logic [SB-1:0] raw, input int ch);
        longint x;
        longint p;
        longint mag;
        longint scaled;
        longint idx;
        longint frac;
        longint a;
        longint b;
        longint t;
        longint w;
        longint wg;
        longint lpn;
        longint mix;
        longint acc;
        longint m;
        longint y;
        x      = longint'($signed(raw));
        p      = x * longint'(shadow_pre_gain);
        mag    = (p < 0) ? -p : p;
        scaled = mag * LUT_DEPTH;
        idx    = scaled >>> IDX_SHIFT;
        // drive beyond the table end takes the last entry
        if (idx >= LUT_DEPTH) begin
            t = tanh_lut[LUT_DEPTH];
        end else begin
            frac = (scaled >>> FRAC_SHIFT) % 65536;
            a    = tanh_lut[int'(idx)];
            b    = tanh_lut[int'(idx) + 1];
            t    = (b >= a) ? a + (((b - a) * frac) >>> 16) : a - (((a - b) * frac) >>> 16);
        end
        w   = (p < 0) ? -t : t;
        w   = round_half_up(w * longint'(shadow_norm_gain), 14);
        wg  = w * (longint'(1) <<< GUARD);
        lpn = wg + round_half_up((lowpass_acc[ch] - wg) * longint'(shadow_tone), 16);
        lpn = clamp_to(lpn, ACC_MIN, ACC_MAX);
        lowpass_acc[ch] = lpn;
        // wet share above one acts as fully wet
        mix = (shadow_wet > 17'd65536) ? 64'sd65536 : longint'(shadow_wet);
        acc = x * (longint'(1) <<< GUARD) * (65536 - mix) + lpn * mix;
        m   = round_half_up(acc, 16);
        y   = round_half_up(m * longint'(shadow_out_gain), 14 + GUARD);
        y   = clamp_to(y, SAMPLE_MIN, SAMPLE_MAX);
        return y[SB-1:0];
    endfunction

    function automatic t_frame predict_frame(input logic [SB-1:0] l, input logic [SB-1:0] r);
        t_frame f;
        if (shadow_enable) begin
            f.left  = shape_sample(l, 0);
            f.right = shape_sample(r, 1);
        end else begin
            f.left  = l;
            f.right = r;
        end
        return f;
    endfunction

    // register write, predictor follows with the width of each register
    task automatic write_reg(input logic [stdist_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [16:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        case (idx)
            stdist_pkg::CFG_ENABLE:      shadow_enable    = val[0];
            stdist_pkg::CFG_PRE_GAIN:    shadow_pre_gain  = val[15:0];
            stdist_pkg::CFG_NORM_GAIN:   shadow_norm_gain = val[14:0];
            stdist_pkg::CFG_TONE_COEFF:  shadow_tone      = val[15:0];
            stdist_pkg::CFG_WET_MIX:     shadow_wet       = val[16:0];
            stdist_pkg::CFG_OUTPUT_GAIN: shadow_out_gain  = val[14:0];
            default: ;
        endcase
    endtask

    // one input request; valid stays high when the next frame follows without a gap
    task automatic send_frame(input logic [SB-1:0] l, input logic [SB-1:0] r);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        expected_frames.push_back(predict_frame(l, r));
        frames_sent++;
    endtask

    // sender pause until every result is back, then let the pipeline settle
    task automatic wait_all_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_frames.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    function automatic logic [SB-1:0] random_sample();
        longint v;
        case ($urandom_range(0, 9))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2, 3:    v = longint'($urandom_range(0, 8191)) - 4096;
            4, 5:    v = longint'($urandom_range(0, 524287)) - 262144;
            default: v = longint'($urandom());
        endcase
        return v[SB-1:0];
    endfunction

    function automatic logic [16:0] pick_value(input int lo, input int hi);
        logic [16:0] v;
        case ($urandom_range(0, 7))
            0:       v = 17'(lo);
            1:       v = 17'(hi);
            2:       v = 17'($urandom());
            default: v = 17'($urandom_range(lo, hi));
        endcase
        return v;
    endfunction

    task automatic randomise_settings(input bit effect_on);
        write_reg(stdist_pkg::CFG_ENABLE, {16'($urandom()), effect_on});
        write_reg(stdist_pkg::CFG_PRE_GAIN, pick_value(1024, 40960));
        write_reg(stdist_pkg::CFG_NORM_GAIN, pick_value(16384, 21510));
        write_reg(stdist_pkg::CFG_TONE_COEFF, pick_value(0, 65535));
        write_reg(stdist_pkg::CFG_WET_MIX, pick_value(0, 65536));
        write_reg(stdist_pkg::CFG_OUTPUT_GAIN, pick_value(1032, 32690));
        settings_count++;
    endtask

    // compare one result with the oldest prediction
    task automatic check_frame(input logic [stdist_pkg::TDATA_BITS-1:0] data);
        t_frame exp_f;
        frames_checked++;
        if (expected_frames.size() == 0) begin
            $display("%0t: unexpected result left=%h right=%h", $realtime,
                     data[SB-1:0], data[2*SB-1:SB]);
            errors++;
        end else begin
            exp_f = expected_frames.pop_front();
            if (data[SB-1:0] !== exp_f.left) begin
                $display("%0t: left_out expected %h actual %h", $realtime,
                         exp_f.left, data[SB-1:0]);
                errors++;
            end
            if (data[2*SB-1:SB] !== exp_f.right) begin
                $display("%0t: right_out expected %h actual %h", $realtime,
                         exp_f.right, data[2*SB-1:SB]);
                errors++;
            end
        end
    endtask

    // receiver: random stall per result, long hold-off on request
    initial begin
        int gap;
        i_m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = rx_idle ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            forever begin
                @(posedge i_clk);
                if (o_m_axis_tvalid && i_m_axis_tready) break;
                if (hold_req > 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (hold_req) @(posedge i_clk);
                    hold_req = 0;
                    i_m_axis_tready <= 1'b1;
                end
            end
            check_frame(o_m_axis_tdata);
        end
    end

    // watchdog on cycles with no request on either side
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // reset defaults, corner samples
    task automatic test_reset_defaults();
        send_frame(24'h000000, 24'h000000);
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h800000, 24'h7fffff);
        send_frame(24'h000001, 24'hffffff);
        send_frame(24'h001000, 24'hfff000);
        send_frame(24'h400000, 24'hc00000);
        send_frame(24'h7fffff, 24'h7fffff);
        send_frame(24'h800000, 24'h800000);
        wait_all_results();
    endtask

    // register extremes, width masking, spare indexes and pass-through
    task automatic test_register_extremes();
        // effect off: upper data bits dropped, filter holds
        write_reg(stdist_pkg::CFG_ENABLE, 17'h1fffe);
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h123456, 24'h9abcde);
        wait_all_results();
        // largest drive, gains and wet share above one, filter and output saturating
        write_reg(stdist_pkg::CFG_ENABLE, 17'h10001);
        write_reg(stdist_pkg::CFG_PRE_GAIN, 17'h1ffff);
        write_reg(stdist_pkg::CFG_NORM_GAIN, 17'h1ffff);
        write_reg(stdist_pkg::CFG_TONE_COEFF, 17'h00000);
        write_reg(stdist_pkg::CFG_WET_MIX, 17'h1ffff);
        write_reg(stdist_pkg::CFG_OUTPUT_GAIN, 17'h1ffff);
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h800000, 24'h7fffff);
        wait_all_results();
        write_reg(stdist_pkg::CFG_TONE_COEFF, 17'h0ffff);
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h000000, 24'h000000);
        wait_all_results();
        // lowest gains, fully dry
        write_reg(stdist_pkg::CFG_PRE_GAIN, 17'd1024);
        write_reg(stdist_pkg::CFG_NORM_GAIN, 17'd16384);
        write_reg(stdist_pkg::CFG_WET_MIX, 17'd0);
        write_reg(stdist_pkg::CFG_OUTPUT_GAIN, 17'd1032);
        send_frame(24'h7fffff, 24'h800000);
        send_frame(24'h00abcd, 24'hfffffb);
        wait_all_results();
        // spare indexes change nothing
        write_reg(CFG_SPARE_A, 17'($urandom()));
        write_reg(CFG_SPARE_B, 17'($urandom()));
        send_frame(24'h200000, 24'he00000);
        wait_all_results();
        write_reg(stdist_pkg::CFG_WET_MIX, stdist_pkg::WET_FULL);
        write_reg(stdist_pkg::CFG_PRE_GAIN, 17'd40960);
        send_frame(24'h010000, 24'hff0000);
        wait_all_results();
        settings_count += 6;
    endtask

    // receiver holds off while the sender keeps offering frames
    task automatic test_output_stall();
        tx_idle  = 1'b0;
        hold_req = HOLD_CYCLES;
        repeat (30) send_frame(random_sample(), random_sample());
        tx_idle = 1'b1;
        wait_all_results();
    endtask

    // sender stops until the pipeline is empty, then resumes on the same filter state
    task automatic test_sender_pause();
        repeat (12) send_frame(random_sample(), random_sample());
        wait_all_results();
        repeat (12) send_frame(random_sample(), random_sample());
        wait_all_results();
    endtask

    // random settings phases, one of them without idling
    task automatic test_random_phases();
        int ph;
        for (ph = 0; ph < 8; ph++) begin
            tx_idle = (ph != 3);
            rx_idle = (ph != 3);
            randomise_settings((ph % 4) != 2);
            repeat (80) send_frame(random_sample(), random_sample());
            wait_all_results();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // stimulus sequence
    initial begin
        fill_tanh_lut();
        shadow_enable    = stdist_pkg::RST_ENABLE;
        shadow_pre_gain  = stdist_pkg::RST_PRE_GAIN;
        shadow_norm_gain = stdist_pkg::RST_NORM_GAIN;
        shadow_tone      = stdist_pkg::RST_TONE_COEFF;
        shadow_wet       = stdist_pkg::RST_WET_MIX;
        shadow_out_gain  = stdist_pkg::RST_OUTPUT_GAIN;
        lowpass_acc[0]   = 0;
        lowpass_acc[1]   = 0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_output_stall();
        test_sender_pause();
        test_random_phases();

        i_s_axis_tvalid <= 1'b0;
        while (expected_frames.size() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d frames through %0d register settings, %0d results checked",
                 frames_sent, settings_count, frames_checked);
        $display("including pass-through, saturation, output hold-off and sender pauses");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/stdist_pkg.sv
rtl/stdist_lane.sv
rtl/stdist_ctrl.sv
rtl/stereo_tanh_distortion_unit.sv
rtl/stdist_checker.sv
verif/tb_top.sv
